// ===== rtl/modbus_rtu_request_framer_defines.svh =====
// assertion macros shared by the request framer
`ifndef MODBUS_RTU_REQUEST_FRAMER_DEFINES_SVH
`define MODBUS_RTU_REQUEST_FRAMER_DEFINES_SVH

// same-cycle implication, held off during reset
`define MBRF_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, held off during reset
`define MBRF_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/mbrf_pkg.sv =====
`default_nettype none

package mbrf_pkg;

  // crc-16/modbus constants
  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'hA001;

  // slave address after reset
  localparam logic [7:0] SLAVE_RESET = 8'h13;

  // register file
  localparam int unsigned PADDR_W   = 3;
  localparam logic        REG_SLAVE = 1'b0;

  // byte positions within a frame
  localparam int unsigned POS_W = 3;
  localparam logic [POS_W-1:0] POS_SLAVE    = 3'd0;
  localparam logic [POS_W-1:0] POS_FUNC     = 3'd1;
  localparam logic [POS_W-1:0] POS_ADDR_HI  = 3'd2;
  localparam logic [POS_W-1:0] POS_ADDR_LO  = 3'd3;
  localparam logic [POS_W-1:0] POS_ZERO     = 3'd4;
  localparam logic [POS_W-1:0] POS_VALUE    = 3'd5;
  localparam logic [POS_W-1:0] POS_CRC_LO   = 3'd6;
  localparam logic [POS_W-1:0] POS_CRC_HI   = 3'd7;

  // request contents held for one frame
  typedef struct packed {
    logic [7:0]  slave_address;
    logic [7:0]  opcode;
    logic [15:0] register_address;
    logic [7:0]  word_value;
  } frame_t;

  // fold one byte into the running crc, lsb first
  function automatic logic [15:0] crc_byte(input logic [15:0] crc_in, input logic [7:0] data);
    logic [15:0] c;
    c = crc_in ^ {8'h00, data};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/mbrf_apb_regs.sv =====
`default_nettype none

module mbrf_apb_regs (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [mbrf_pkg::PADDR_W-1:0] paddr,
  input  wire logic [31:0]                 pwdata,
  output logic      [31:0]                 prdata,
  output logic                             pready,
  output logic      [7:0]                  slave_address
);
  import mbrf_pkg::*;

  logic [7:0] slave_r;
  logic [7:0] slave_nxt;
  logic       wr_en;

  // register index is the word address
  assign wr_en  = psel && penable && pwrite && (paddr[PADDR_W-1] == REG_SLAVE);
  assign pready = 1'b1;

  // write decode
  always_comb begin
    slave_nxt = slave_r;
    if (wr_en) begin
      slave_nxt = pwdata[7:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slave_r <= SLAVE_RESET;
    end else begin
      slave_r <= slave_nxt;
    end
  end

  // read back
  always_comb begin
    prdata = 32'h0;
    if (paddr[PADDR_W-1] == REG_SLAVE) begin
      prdata = {24'h0, slave_r};
    end
  end

  assign slave_address = slave_r;

endmodule

`default_nettype wire

// ===== rtl/mbrf_serializer.sv =====
`default_nettype none

module mbrf_serializer (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             start,
  input  wire mbrf_pkg::frame_t frame_in,
  output logic                  busy,
  output logic                  out_strobe,
  output logic [7:0]            out_tx_byte,
  output logic                  out_frame_last
);
  import mbrf_pkg::*;

  frame_t           frame_r, frame_nxt;
  logic [15:0]      crc_r, crc_nxt;
  logic [POS_W-1:0] pos_r, pos_nxt;
  logic             active_r, active_nxt;
  logic             strobe_r, strobe_nxt;
  logic [7:0]       byte_r, byte_nxt;
  logic             last_r, last_nxt;
  logic             accept;
  logic [7:0]       cur_byte;

  // a new request may load while the final byte goes out
  assign busy   = active_r && (pos_r != POS_CRC_HI);
  assign accept = start && !busy;

  // byte for the current position
  always_comb begin
    case (pos_r)
      POS_SLAVE:   cur_byte = frame_r.slave_address;
      POS_FUNC:    cur_byte = frame_r.opcode;
      POS_ADDR_HI: cur_byte = frame_r.register_address[15:8];
      POS_ADDR_LO: cur_byte = frame_r.register_address[7:0];
      POS_ZERO:    cur_byte = 8'h00;
      POS_VALUE:   cur_byte = frame_r.word_value;
      POS_CRC_LO:  cur_byte = crc_r[7:0];
      default:     cur_byte = crc_r[15:8];
    endcase
  end

  // sequencer and running crc
  always_comb begin
    frame_nxt  = frame_r;
    crc_nxt    = crc_r;
    pos_nxt    = pos_r;
    active_nxt = active_r;
    if (active_r) begin
      pos_nxt = pos_r + 1'b1;
      if (pos_r == POS_CRC_HI) begin
        active_nxt = 1'b0;
      end
      if (pos_r <= POS_VALUE) begin
        crc_nxt = crc_byte(crc_r, cur_byte);
      end
    end
    if (accept) begin
      frame_nxt  = frame_in;
      crc_nxt    = CRC_INIT;
      pos_nxt    = POS_SLAVE;
      active_nxt = 1'b1;
    end
  end

  // output beat register
  always_comb begin
    strobe_nxt = active_r;
    byte_nxt   = cur_byte;
    last_nxt   = active_r && (pos_r == POS_CRC_HI);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
      pos_r    <= POS_SLAVE;
      strobe_r <= 1'b0;
      last_r   <= 1'b0;
    end else begin
      active_r <= active_nxt;
      pos_r    <= pos_nxt;
      strobe_r <= strobe_nxt;
      last_r   <= last_nxt;
    end
  end

  always_ff @(posedge clk) begin
    frame_r <= frame_nxt;
    crc_r   <= crc_nxt;
    byte_r  <= byte_nxt;
  end

  assign out_strobe     = strobe_r;
  assign out_tx_byte    = byte_r;
  assign out_frame_last = last_r;

endmodule

`default_nettype wire

// ===== rtl/modbus_rtu_request_framer.sv =====
// start is taken into the sequencer state, which feeds the output beat register that strobes the first frame byte
// the eight frame bytes go out on consecutive cycles, the last one flagged by out_frame_last
// throughput: a new request is taken before the previous frame has left the one-byte-per-cycle output port
// start is taken again in the cycle the crc low byte is on the output
// reset (synchronous, active low) idles the sequencer, drops the strobe, slave address 0x13
`default_nettype none
`include "modbus_rtu_request_framer_defines.svh"

module modbus_rtu_request_framer (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         start,
  output logic                              busy,
  input  wire logic [7:0]                   in_opcode,
  input  wire logic [15:0]                  in_register_address,
  input  wire logic [7:0]                   in_word_value,
  output logic                              out_strobe,
  output logic [7:0]                        out_tx_byte,
  output logic                              out_frame_last,
  input  wire logic                         psel,
  input  wire logic                         penable,
  input  wire logic                         pwrite,
  input  wire logic [mbrf_pkg::PADDR_W-1:0] paddr,
  input  wire logic [31:0]                  pwdata,
  output logic      [31:0]                  prdata,
  output logic                              pready
);
  import mbrf_pkg::*;

  logic [7:0] slave_address;
  frame_t     frame_in;

  // configuration registers
  mbrf_apb_regs u_regs (
    .clk           (clk),
    .rst_n         (rst_n),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .slave_address (slave_address)
  );

  // request contents as captured on start
  always_comb begin
    frame_in.slave_address    = slave_address;
    frame_in.opcode           = in_opcode;
    frame_in.register_address = in_register_address;
    frame_in.word_value       = in_word_value;
  end

  // byte sequencer with crc
  mbrf_serializer u_ser (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .frame_in       (frame_in),
    .busy           (busy),
    .out_strobe     (out_strobe),
    .out_tx_byte    (out_tx_byte),
    .out_frame_last (out_frame_last)
  );

  // checks
  `MBRF_ASSERT_NEXT(a_start_goes_busy, clk, rst_n, start && !busy, busy,
                    "accepted request did not raise busy")
  `MBRF_ASSERT_NOW(a_last_has_strobe, clk, rst_n, out_frame_last, out_strobe,
                   "last flag without a beat")
  `MBRF_ASSERT_NEXT(a_beats_contiguous, clk, rst_n, out_strobe && !out_frame_last, out_strobe,
                    "gap inside a frame")
  `MBRF_ASSERT_NEXT(a_busy_feeds_output, clk, rst_n, busy, out_strobe,
                    "busy without output beats")

endmodule

`default_nettype wire
